// ----- hw/rtl/vshfd_pkg.sv -----
// Shared types and constants for the vertical swipe, hold and flick detector.
package vshfd_pkg;

    // Field widths
    localparam int COL_W  = 4;
    localparam int ROW_W  = 4;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Default history depth
    localparam int HISTORY_DEFAULT = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLICK_WINDOW    = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] VERTICAL_WINDOW_RST = 8'd3;
    localparam logic [CFG_W-1:0] HOLD_TIME_RST       = 8'd3;
    localparam logic [CFG_W-1:0] FLICK_WINDOW_RST    = 8'd2;

    // Input item
    typedef struct packed {
        logic [COL_W-1:0]  cell_col;
        logic [ROW_W-1:0]  cell_row;
        logic [TIME_W-1:0] now_seconds;
    } cell_item_t;

    // Result item
    typedef struct packed {
        logic vertical_seen;
        logic hold_seen;
        logic flick_seen;
    } flags_item_t;

    // One history entry
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [TIME_W-1:0] first_seen;
        logic [TIME_W-1:0] last_seen;
    } entry_t;

endpackage

// ----- hw/rtl/vertical_swipe_hold_flick_detector.sv -----
// Top level: history update and gesture evaluation over a ring held in memory.
//
//  channel  | signals                         | direction | item
//  ---------+---------------------------------+-----------+------------------------------------
//  cell     | cell_valid/cell_stall/cell_item | in        | cell_col, cell_row, now_seconds
//  flags    | flags_valid/flags_stall/flags   | out       | vertical_seen, hold_seen, flick_seen
//  cfg      | cfg_we/cfg_index/cfg_data       | in        | register write, no handshake
//
// An item runs from accept through one read-modify-write of the newest entry, then a walk
// over the ring, one memory read per entry of the history after the update (HISTORY
// entries once the history is full), then a drain state and the result load. rst_n
// clears the sequencer, ring pointers and registers at once; no clearing pass. The
// block takes a new item while its last result is still stalled, and holds the next
// result until the output register frees up.
module vertical_swipe_hold_flick_detector #(
    parameter int HISTORY = vshfd_pkg::HISTORY_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cell_valid,
    output logic                              cell_stall,
    input  vshfd_pkg::cell_item_t             cell_item,
    output logic                              flags_valid,
    input  logic                              flags_stall,
    output vshfd_pkg::flags_item_t            flags,
    input  logic                              cfg_we,
    input  logic [vshfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vshfd_pkg::CFG_W-1:0]       cfg_data
);
    import vshfd_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY);
    localparam int CNT_W  = $clog2(HISTORY + 1);
    localparam int KW     = (CNT_W + 1 > ROW_W + 1) ? CNT_W + 1 : ROW_W + 1;

    typedef enum logic [2:0] {S_IDLE, S_NEWEST, S_WALK, S_DRAIN, S_DONE} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SLOT_W-1:0] oldest_reg;
    logic [CNT_W-1:0]  k_reg;
    logic              chk_valid_reg;
    logic [CNT_W-1:0]  chk_k_reg;
    logic [CFG_W-1:0]  vwin_reg;
    logic [CFG_W-1:0]  hold_reg;
    logic [CFG_W-1:0]  fwin_reg;
    flags_item_t       flags_reg;
    logic              flags_valid_reg;

    // Datapath registers
    cell_item_t        item_reg;
    logic [SLOT_W-1:0] newest_slot_reg;
    logic [COL_W-1:0]  first_col_reg;
    logic [TIME_W-1:0] first_end_reg;
    logic              vert_ok_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic [ROW_W-1:0]  a_row_reg;
    logic [TIME_W-1:0] a_end_reg;
    logic [COL_W-1:0]  b_col_reg;
    logic [ROW_W-1:0]  b_row_reg;
    flags_item_t       res_reg;

    // Memory port
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [SLOT_W-1:0] rd_addr;
    entry_t            rd_data;

    logic [SLOT_W-1:0] newest_now;
    logic [SLOT_W-1:0] append_slot;
    logic              ignore_cell;
    logic              same_cell;
    logic              full;
    logic              last_chk;
    logic              vert_step;
    flags_item_t       res_next;

    // Ring slot of logical entry k
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0] k);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(k);
        if (sum >= (CNT_W + 1)'(HISTORY))
        begin
            sum = sum - (CNT_W + 1)'(HISTORY);
        end
        return sum[SLOT_W-1:0];
    endfunction

    vshfd_hist_mem #(
        .DEPTH(HISTORY)
    ) u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Update decision for the newest entry
    always_comb
    begin
        newest_now  = slot_of(oldest_reg, count_reg - CNT_W'(1));
        append_slot = (count_reg < CNT_W'(HISTORY)) ? slot_of(oldest_reg, count_reg)
                                                      : oldest_reg;
        ignore_cell = (item_reg.cell_col == '0) && (item_reg.cell_row == '0);
        same_cell   = (rd_data.col == item_reg.cell_col) && (rd_data.row == item_reg.cell_row);
        rd_addr     = (state_reg == S_IDLE) ? newest_now : slot_of(oldest_reg, k_reg);
        wr_en       = (state_reg == S_NEWEST) && !ignore_cell;
        if (same_cell)
        begin
            wr_addr            = newest_slot_reg;
            wr_data            = rd_data;
            wr_data.last_seen  = item_reg.now_seconds;
        end
        else
        begin
            wr_addr            = append_slot;
            wr_data.col        = item_reg.cell_col;
            wr_data.row        = item_reg.cell_row;
            wr_data.first_seen = item_reg.now_seconds;
            wr_data.last_seen  = item_reg.now_seconds;
        end
    end

    // Per-entry checks during the walk
    always_comb
    begin
        full     = (count_reg == CNT_W'(HISTORY));
        last_chk = (chk_k_reg == count_reg - CNT_W'(1));
        if (chk_k_reg == '0)
        begin
            vert_step = (rd_data.row == ROW_W'(1));
        end
        else
        begin
            vert_step = vert_ok_reg && (rd_data.col == first_col_reg)
                        && (KW'(rd_data.row) == KW'(chk_k_reg) + KW'(1));
        end
        res_next.hold_seen     = (rd_data.last_seen - rd_data.first_seen) >= TIME_W'(hold_reg);
        res_next.vertical_seen = full && vert_step
                                 && ((rd_data.last_seen - first_end_reg) < TIME_W'(vwin_reg));
        res_next.flick_seen    = full
                                 && ((rd_data.last_seen - a_end_reg) < TIME_W'(fwin_reg))
                                 && (a_col_reg == rd_data.col) && (a_row_reg == rd_data.row)
                                 && (b_col_reg == a_col_reg)
                                 && (({1'b0, b_row_reg} == {1'b0, a_row_reg} + 5'd1)
                                     || ({1'b0, a_row_reg} == {1'b0, b_row_reg} + 5'd1));
    end

    // Datapath capture
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cell_valid)
        begin
            item_reg        <= cell_item;
            newest_slot_reg <= newest_now;
        end
        if (chk_valid_reg)
        begin
            vert_ok_reg <= vert_step;
            if (chk_k_reg == '0)
            begin
                first_col_reg <= rd_data.col;
                first_end_reg <= rd_data.last_seen;
            end
            if (chk_k_reg == CNT_W'(HISTORY - 3))
            begin
                a_col_reg <= rd_data.col;
                a_row_reg <= rd_data.row;
                a_end_reg <= rd_data.last_seen;
            end
            if (chk_k_reg == CNT_W'(HISTORY - 2))
            begin
                b_col_reg <= rd_data.col;
                b_row_reg <= rd_data.row;
            end
            if (last_chk)
            begin
                res_reg <= res_next;
            end
        end
    end

    // Sequencer, ring pointers, registers and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= CNT_W'(1);
            oldest_reg      <= '0;
            k_reg           <= '0;
            chk_valid_reg   <= 1'b0;
            chk_k_reg       <= '0;
            vwin_reg        <= VERTICAL_WINDOW_RST;
            hold_reg        <= HOLD_TIME_RST;
            fwin_reg        <= FLICK_WINDOW_RST;
            flags_reg       <= '0;
            flags_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_VERTICAL_WINDOW: vwin_reg <= cfg_data;
                    CFG_HOLD_TIME:       hold_reg <= cfg_data;
                    CFG_FLICK_WINDOW:    fwin_reg <= cfg_data;
                    default: ;
                endcase
            end

            chk_valid_reg <= (state_reg == S_WALK);
            chk_k_reg     <= k_reg;

            // Result taken; S_DONE handles its own reload
            if (flags_valid_reg && !flags_stall && state_reg != S_DONE)
            begin
                flags_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cell_valid)
                    begin
                        state_reg <= S_NEWEST;
                    end
                end
                S_NEWEST:
                begin
                    if (!ignore_cell && !same_cell)
                    begin
                        if (count_reg < CNT_W'(HISTORY))
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            oldest_reg <= slot_of(oldest_reg, CNT_W'(1));
                        end
                    end
                    k_reg     <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (k_reg == count_reg - CNT_W'(1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + CNT_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!flags_valid_reg || !flags_stall)
                    begin
                        flags_reg       <= res_reg;
                        flags_valid_reg <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cell_stall  = (state_reg != S_IDLE);
    assign flags_valid = flags_valid_reg;
    assign flags       = flags_reg;

endmodule

// ----- hw/rtl/vshfd_hist_mem.sv -----
// History memory: one write port, one registered read port, slot 0 reads zero until written.
module vshfd_hist_mem #(
    parameter int DEPTH = vshfd_pkg::HISTORY_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  vshfd_pkg::entry_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    output vshfd_pkg::entry_t rd_data
);
    import vshfd_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_q_reg;
    logic   slot0_written_reg;
    logic   rd_zero_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    // Slot 0 starts as the empty cell at time 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_written_reg <= 1'b0;
            rd_zero_reg       <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_addr == '0)
            begin
                slot0_written_reg <= 1'b1;
            end
            rd_zero_reg <= (rd_addr == '0) && !slot0_written_reg;
        end
    end

    assign rd_data = rd_zero_reg ? '0 : rd_q_reg;

endmodule

// ----- hw/rtl/vshfd_checker.sv -----
// Port-level checks for the detector, bound to the top level.
module vshfd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cell_valid,
    input logic                            cell_stall,
    input logic                            flags_valid,
    input logic                            flags_stall,
    input vshfd_pkg::flags_item_t          flags
);
    import vshfd_pkg::*;

    // One item at a time: an accept closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_stall |=> cell_stall)
        else $error("input taken again right after an accept");

    // A new result only appears at the end of an item's work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flags_valid) |-> $past(cell_stall))
        else $error("result appeared with no item in flight");

    // Rows rising through the history exclude an out-and-back flick
    a_gestures_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        flags_valid |-> !(flags.vertical_seen && flags.flick_seen))
        else $error("vertical and flick flagged together");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        flags_valid && flags_stall |=> flags_valid && $stable(flags))
        else $error("stalled result changed");

endmodule

bind vertical_swipe_hold_flick_detector vshfd_checker u_vshfd_checker (.*);
